FILE: hdl/vwm_pkg.sv
package vwm_pkg;

    // Median window limits and history reset value, in millivolts
    localparam logic [15:0] MV_VALID_MIN  = 16'd10000;
    localparam logic [15:0] MV_VALID_MAX  = 16'd35000;
    localparam logic [15:0] MV_HIST_RESET = 16'd24000;

    // Alarm levels
    localparam logic [1:0] LVL_NORMAL   = 2'd0;
    localparam logic [1:0] LVL_WARNING  = 2'd1;
    localparam logic [1:0] LVL_CRITICAL = 2'd2;

    // Register indexes (byte address = 4 * index)
    localparam int          ADDR_W            = 5;
    localparam logic [2:0]  REG_WARN_LOW      = 3'd0;
    localparam logic [2:0]  REG_WARN_CRITICAL = 3'd1;
    localparam logic [2:0]  REG_HYSTERESIS    = 3'd2;
    localparam logic [2:0]  REG_SENSOR_TMO    = 3'd3;
    localparam logic [2:0]  REG_WARN_BLINK    = 3'd4;
    localparam logic [2:0]  REG_CRIT_BLINK    = 3'd5;
    localparam logic [2:0]  REG_DEBOUNCE      = 3'd6;

    // Register reset values
    localparam logic [15:0] RST_WARN_LOW      = 16'd22000;
    localparam logic [15:0] RST_WARN_CRITICAL = 16'd21000;
    localparam logic [15:0] RST_HYSTERESIS    = 16'd500;
    localparam logic [31:0] RST_SENSOR_TMO    = 32'd1000;
    localparam logic [15:0] RST_WARN_BLINK    = 16'd500;
    localparam logic [15:0] RST_CRIT_BLINK    = 16'd150;
    localparam logic [15:0] RST_DEBOUNCE      = 16'd100;

    typedef struct packed {
        logic [15:0] warn_low_mv;
        logic [15:0] warn_critical_mv;
        logic [15:0] hysteresis_mv;
        logic [31:0] sensor_timeout_ms;
        logic [15:0] warn_blink_ms;
        logic [15:0] crit_blink_ms;
        logic [15:0] debounce_ms;
    } vwm_cfg_t;

    typedef struct packed {
        logic [1:0] alarm_level;
        logic       buzzer;
        logic       warn_relay;
        logic       fault_raise;
    } vwm_result_t;

    // Median of three unsigned samples
    function automatic logic [15:0] median3(input logic [15:0] a,
                                            input logic [15:0] b,
                                            input logic [15:0] c);
        logic [15:0] lo_ab;
        logic [15:0] hi_ab;
        logic [15:0] lo_hc;
        lo_ab = (a < b) ? a : b;
        hi_ab = (a > b) ? a : b;
        lo_hc = (hi_ab < c) ? hi_ab : c;
        return (lo_ab > lo_hc) ? lo_ab : lo_hc;
    endfunction

endpackage

FILE: hdl/voltage_warning_monitor_unit.sv
// Supply undervoltage monitor with median-of-three filter and alarm levels.
// Input requests (s_time_ms, s_voltage_mv, s_sensor_update_ms) enter on a
// valid/ready channel; each one yields exactly one result request
// (m_alarm_level, m_buzzer, m_warn_relay, m_fault_raise) on the m_ channel.
// Thresholds, timeout, blink periods and debounce time are set through the
// APB port at byte address 4*index; write them only while the block is idle.
// A request accepted into the input register passes through the step logic
// into the result register as soon as that register is free to load.
// Throughput: one request per cycle unless m_ready stalls the output; the
// median, fail-safe, hysteresis, debounce and blink logic is one combinational
// pass between the input and result registers, with state committed as a result loads.
// When m_ready is low the result register holds, the input register holds
// the next request, and s_ready drops only when both are full.
// Reset (aresetn low, synchronous) restores register defaults, fills the
// sample history with 24000 mV, sets level normal and empties both stages.
module voltage_warning_monitor_unit
    import vwm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [31:0]       s_time_ms,
    input  logic [15:0]       s_voltage_mv,
    input  logic [31:0]       s_sensor_update_ms,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_alarm_level,
    output logic              m_buzzer,
    output logic              m_warn_relay,
    output logic              m_fault_raise,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    vwm_cfg_t    cfg;
    vwm_result_t step_res;
    vwm_result_t res_reg;
    logic        in_vld_reg;
    logic        out_vld_reg;
    logic [31:0] time_reg;
    logic [15:0] mv_reg;
    logic [31:0] upd_reg;
    logic        advance;

    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    vwm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vwm_step u_step (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .commit           (advance),
        .time_ms          (time_reg),
        .voltage_mv       (mv_reg),
        .sensor_update_ms (upd_reg),
        .cfg              (cfg),
        .result           (step_res)
    );

    // Input register: load on accept, drop when passed on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            time_reg <= s_time_ms;
            mv_reg   <= s_voltage_mv;
            upd_reg  <= s_sensor_update_ms;
        end
    end

    // Result register: hold while stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= step_res;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_alarm_level = res_reg.alarm_level;
    assign m_buzzer      = res_reg.buzzer;
    assign m_warn_relay  = res_reg.warn_relay;
    assign m_fault_raise = res_reg.fault_raise;

endmodule

FILE: hdl/vwm_regs.sv
module vwm_regs
    import vwm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output vwm_cfg_t          cfg
);

    vwm_cfg_t   cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    // Write registers on the access phase of a write request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.warn_low_mv       <= RST_WARN_LOW;
            cfg_reg.warn_critical_mv  <= RST_WARN_CRITICAL;
            cfg_reg.hysteresis_mv     <= RST_HYSTERESIS;
            cfg_reg.sensor_timeout_ms <= RST_SENSOR_TMO;
            cfg_reg.warn_blink_ms     <= RST_WARN_BLINK;
            cfg_reg.crit_blink_ms     <= RST_CRIT_BLINK;
            cfg_reg.debounce_ms       <= RST_DEBOUNCE;
        end else if (wr_en) begin
            case (reg_idx)
                REG_WARN_LOW:      cfg_reg.warn_low_mv       <= pwdata[15:0];
                REG_WARN_CRITICAL: cfg_reg.warn_critical_mv  <= pwdata[15:0];
                REG_HYSTERESIS:    cfg_reg.hysteresis_mv     <= pwdata[15:0];
                REG_SENSOR_TMO:    cfg_reg.sensor_timeout_ms <= pwdata;
                REG_WARN_BLINK:    cfg_reg.warn_blink_ms     <= pwdata[15:0];
                REG_CRIT_BLINK:    cfg_reg.crit_blink_ms     <= pwdata[15:0];
                REG_DEBOUNCE:      cfg_reg.debounce_ms       <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            REG_WARN_LOW:      prdata = {16'd0, cfg_reg.warn_low_mv};
            REG_WARN_CRITICAL: prdata = {16'd0, cfg_reg.warn_critical_mv};
            REG_HYSTERESIS:    prdata = {16'd0, cfg_reg.hysteresis_mv};
            REG_SENSOR_TMO:    prdata = cfg_reg.sensor_timeout_ms;
            REG_WARN_BLINK:    prdata = {16'd0, cfg_reg.warn_blink_ms};
            REG_CRIT_BLINK:    prdata = {16'd0, cfg_reg.crit_blink_ms};
            REG_DEBOUNCE:      prdata = {16'd0, cfg_reg.debounce_ms};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

FILE: hdl/vwm_step.sv
module vwm_step
    import vwm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        commit,
    input  logic [31:0] time_ms,
    input  logic [15:0] voltage_mv,
    input  logic [31:0] sensor_update_ms,
    input  vwm_cfg_t    cfg,
    output vwm_result_t result
);

    // Two most recent samples; the oldest one drops out on each request
    logic [15:0] hist_mid_reg;
    logic [15:0] hist_new_reg;
    logic [1:0]  level_reg,         level_next;
    logic [31:0] last_toggle_reg,   last_toggle_next;
    logic        phase_reg,         phase_next;
    logic [31:0] change_start_reg,  change_start_next;
    logic        pending_reg,       pending_next;

    logic [15:0] med;
    logic [31:0] sensor_age;
    logic        fault;
    logic [16:0] up_low;
    logic [16:0] up_crit;
    logic [1:0]  proposal;
    logic [1:0]  level_deb;
    logic [31:0] toggle_deb;
    logic        phase_deb;
    logic [15:0] period;
    logic        blink_due;

    assign med        = median3(hist_mid_reg, hist_new_reg, voltage_mv);
    assign sensor_age = time_ms - sensor_update_ms;
    assign fault      = (med < MV_VALID_MIN) || (med > MV_VALID_MAX)
                        || (sensor_age > cfg.sensor_timeout_ms);
    assign up_low     = {1'b0, cfg.warn_low_mv} + {1'b0, cfg.hysteresis_mv};
    assign up_crit    = {1'b0, cfg.warn_critical_mv} + {1'b0, cfg.hysteresis_mv};

    // Propose the next level from the hysteresis thresholds
    always_comb begin
        proposal = level_reg;
        case (level_reg)
            LVL_NORMAL: begin
                if (med < cfg.warn_low_mv) proposal = LVL_WARNING;
            end
            LVL_WARNING: begin
                if (med < cfg.warn_critical_mv) proposal = LVL_CRITICAL;
                else if ({1'b0, med} > up_low) proposal = LVL_NORMAL;
            end
            LVL_CRITICAL: begin
                if ({1'b0, med} > up_crit) proposal = LVL_WARNING;
            end
            default: proposal = level_reg;
        endcase
    end

    // Debounce the proposal, then run the buzzer blink
    always_comb begin
        level_deb         = level_reg;
        toggle_deb        = last_toggle_reg;
        phase_deb         = phase_reg;
        pending_next      = pending_reg;
        change_start_next = change_start_reg;
        if (proposal != level_reg) begin
            if (!pending_reg) begin
                pending_next      = 1'b1;
                change_start_next = time_ms;
            end else if ((time_ms - change_start_reg) > {16'd0, cfg.debounce_ms}) begin
                level_deb    = proposal;
                toggle_deb   = time_ms;
                phase_deb    = 1'b0;
                pending_next = 1'b0;
            end
        end else begin
            pending_next = 1'b0;
        end

        period    = (level_deb == LVL_WARNING) ? cfg.warn_blink_ms : cfg.crit_blink_ms;
        blink_due = (level_deb != LVL_NORMAL)
                    && ((time_ms - toggle_deb) >= {16'd0, period});

        level_next       = level_deb;
        last_toggle_next = blink_due ? time_ms : toggle_deb;
        phase_next       = blink_due ? ~phase_deb : phase_deb;

        result.fault_raise = 1'b0;
        result.alarm_level = level_deb;
        result.buzzer      = (level_deb != LVL_NORMAL) && phase_next;
        result.warn_relay  = (level_deb != LVL_NORMAL);

        // Fail-safe: force critical, leave debounce and blink state alone
        if (fault) begin
            level_next         = LVL_CRITICAL;
            last_toggle_next   = last_toggle_reg;
            phase_next         = phase_reg;
            pending_next       = pending_reg;
            change_start_next  = change_start_reg;
            result.alarm_level = LVL_CRITICAL;
            result.buzzer      = 1'b1;
            result.warn_relay  = 1'b1;
            result.fault_raise = 1'b1;
        end
    end

    // Commit state once per request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_mid_reg     <= MV_HIST_RESET;
            hist_new_reg     <= MV_HIST_RESET;
            level_reg        <= LVL_NORMAL;
            last_toggle_reg  <= 32'd0;
            phase_reg        <= 1'b0;
            change_start_reg <= 32'd0;
            pending_reg      <= 1'b0;
        end else if (commit) begin
            hist_mid_reg     <= hist_new_reg;
            hist_new_reg     <= voltage_mv;
            level_reg        <= level_next;
            last_toggle_reg  <= last_toggle_next;
            phase_reg        <= phase_next;
            change_start_reg <= change_start_next;
            pending_reg      <= pending_next;
        end
    end

endmodule

FILE: sim/vwm_alarm_check.sv
module vwm_alarm_check
    import vwm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [31:0]       s_time_ms,
    input  logic [15:0]       s_voltage_mv,
    input  logic [31:0]       s_sensor_update_ms,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [1:0]        m_alarm_level,
    input  logic              m_buzzer,
    input  logic              m_warn_relay,
    input  logic              m_fault_raise,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic [31:0]       prdata,
    input  logic              pready,
    output int                n_mismatch,
    output int                alarms_due
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow of the register file and of the alarm state
    vwm_cfg_t    cfg;
    logic [15:0] hist [3];
    logic [1:0]  level;
    logic [31:0] last_toggle;
    logic        buzz_phase;
    logic [31:0] chg_start;
    logic        chg_pending;

    vwm_result_t alarm_due_q [$];

    // Advance the alarm state by one sample and return the outputs it drives
    function automatic vwm_result_t step_alarm(input logic [31:0] now,
                                               input logic [15:0] mv,
                                               input logic [31:0] upd);
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] med;
        logic [16:0] low_up;
        logic [16:0] crit_up;
        logic [31:0] age;
        logic [31:0] held;
        logic [31:0] since_toggle;
        logic [15:0] blink;
        logic [1:0]  prop;
        vwm_result_t r;

        hist[0] = hist[1];
        hist[1] = hist[2];
        hist[2] = mv;
        lo  = (hist[0] < hist[1]) ? hist[0] : hist[1];
        hi  = (hist[0] < hist[1]) ? hist[1] : hist[0];
        med = (hist[2] < lo) ? lo : ((hist[2] > hi) ? hi : hist[2]);
        age = now - upd;

        // Fail-safe: out-of-window median or stale sensor
        if (med < MV_VALID_MIN || med > MV_VALID_MAX || age > cfg.sensor_timeout_ms) begin
            level         = LVL_CRITICAL;
            r.alarm_level = LVL_CRITICAL;
            r.buzzer      = 1'b1;
            r.warn_relay  = 1'b1;
            r.fault_raise = 1'b1;
            return r;
        end

        // Hysteresis proposal, sums kept at 17 bits
        low_up  = {1'b0, cfg.warn_low_mv} + {1'b0, cfg.hysteresis_mv};
        crit_up = {1'b0, cfg.warn_critical_mv} + {1'b0, cfg.hysteresis_mv};
        prop = level;
        case (level)
            LVL_NORMAL: begin
                if (med < cfg.warn_low_mv) prop = LVL_WARNING;
            end
            LVL_WARNING: begin
                if (med < cfg.warn_critical_mv) prop = LVL_CRITICAL;
                else if ({1'b0, med} > low_up) prop = LVL_NORMAL;
            end
            LVL_CRITICAL: begin
                if ({1'b0, med} > crit_up) prop = LVL_WARNING;
            end
            default: ;
        endcase

        // Debounce: accept only after the proposal held strictly longer
        if (prop != level) begin
            held = now - chg_start;
            if (!chg_pending) begin
                chg_pending = 1'b1;
                chg_start   = now;
            end else if (held > {16'h0, cfg.debounce_ms}) begin
                level       = prop;
                last_toggle = now;
                buzz_phase  = 1'b0;
                chg_pending = 1'b0;
            end
        end else begin
            chg_pending = 1'b0;
        end

        r.fault_raise = 1'b0;
        r.alarm_level = level;
        if (level == LVL_NORMAL) begin
            r.buzzer     = 1'b0;
            r.warn_relay = 1'b0;
            return r;
        end

        // Blink the buzzer at the level's period
        blink        = (level == LVL_WARNING) ? cfg.warn_blink_ms : cfg.crit_blink_ms;
        since_toggle = now - last_toggle;
        if (since_toggle >= {16'h0, blink}) begin
            last_toggle = now;
            buzz_phase  = ~buzz_phase;
        end
        r.buzzer     = buzz_phase;
        r.warn_relay = 1'b1;
        return r;
    endfunction

    always @(posedge aclk) begin
        vwm_result_t want;
        logic [31:0] rd_want;
        logic [31:0] rd_mask;

        if (!aresetn) begin
            cfg.warn_low_mv       = RST_WARN_LOW;
            cfg.warn_critical_mv  = RST_WARN_CRITICAL;
            cfg.hysteresis_mv     = RST_HYSTERESIS;
            cfg.sensor_timeout_ms = RST_SENSOR_TMO;
            cfg.warn_blink_ms     = RST_WARN_BLINK;
            cfg.crit_blink_ms     = RST_CRIT_BLINK;
            cfg.debounce_ms       = RST_DEBOUNCE;
            for (int i = 0; i < 3; i++) hist[i] = MV_HIST_RESET;
            level       = LVL_NORMAL;
            last_toggle = '0;
            buzz_phase  = 1'b0;
            chg_start   = '0;
            chg_pending = 1'b0;
            alarm_due_q.delete();
        end else begin
            // Compare the result request against the oldest prediction
            if (m_valid === 1'b1 && m_ready) begin
                if (alarm_due_q.size() == 0) begin
                    $error("result request with no prediction waiting");
                    n_mismatch++;
                end else begin
                    want = alarm_due_q.pop_front();
                    if (m_alarm_level !== want.alarm_level) begin
                        $error("alarm_level expected %0d actual %0d",
                               want.alarm_level, m_alarm_level);
                        n_mismatch++;
                    end
                    if (m_buzzer !== want.buzzer) begin
                        $error("buzzer expected %0b actual %0b", want.buzzer, m_buzzer);
                        n_mismatch++;
                    end
                    if (m_warn_relay !== want.warn_relay) begin
                        $error("warn_relay expected %0b actual %0b",
                               want.warn_relay, m_warn_relay);
                        n_mismatch++;
                    end
                    if (m_fault_raise !== want.fault_raise) begin
                        $error("fault_raise expected %0b actual %0b",
                               want.fault_raise, m_fault_raise);
                        n_mismatch++;
                    end
                end
            end

            // Predict each accepted input request
            if (s_valid && s_ready)
                alarm_due_q.push_back(step_alarm(s_time_ms, s_voltage_mv,
                                                 s_sensor_update_ms));

            // Track register writes, check register reads
            if (psel && penable && pready) begin
                rd_mask = 32'h0000_FFFF;
                rd_want = '0;
                case (paddr[ADDR_W-1:2])
                    REG_WARN_LOW: begin
                        if (pwrite) cfg.warn_low_mv = pwdata[15:0];
                        rd_want[15:0] = cfg.warn_low_mv;
                    end
                    REG_WARN_CRITICAL: begin
                        if (pwrite) cfg.warn_critical_mv = pwdata[15:0];
                        rd_want[15:0] = cfg.warn_critical_mv;
                    end
                    REG_HYSTERESIS: begin
                        if (pwrite) cfg.hysteresis_mv = pwdata[15:0];
                        rd_want[15:0] = cfg.hysteresis_mv;
                    end
                    REG_SENSOR_TMO: begin
                        if (pwrite) cfg.sensor_timeout_ms = pwdata;
                        rd_want = cfg.sensor_timeout_ms;
                        rd_mask = 32'hFFFF_FFFF;
                    end
                    REG_WARN_BLINK: begin
                        if (pwrite) cfg.warn_blink_ms = pwdata[15:0];
                        rd_want[15:0] = cfg.warn_blink_ms;
                    end
                    REG_CRIT_BLINK: begin
                        if (pwrite) cfg.crit_blink_ms = pwdata[15:0];
                        rd_want[15:0] = cfg.crit_blink_ms;
                    end
                    REG_DEBOUNCE: begin
                        if (pwrite) cfg.debounce_ms = pwdata[15:0];
                        rd_want[15:0] = cfg.debounce_ms;
                    end
                    default: rd_mask = '0;
                endcase
                if (!pwrite && ((prdata & rd_mask) !== (rd_want & rd_mask))) begin
                    $error("prdata at 0x%0h expected 0x%0h actual 0x%0h",
                           paddr, rd_want & rd_mask, prdata & rd_mask);
                    n_mismatch++;
                end
            end
        end
        alarms_due <= alarm_due_q.size();
    end

endmodule

FILE: sim/tb_top.sv
module tb_top;
    import vwm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic              aclk               = 1'b0;
    logic              aresetn            = 1'b0;
    logic              s_valid            = 1'b0;
    logic              s_ready;
    logic [31:0]       s_time_ms          = '0;
    logic [15:0]       s_voltage_mv       = '0;
    logic [31:0]       s_sensor_update_ms = '0;
    logic              m_valid;
    logic              m_ready            = 1'b0;
    logic [1:0]        m_alarm_level;
    logic              m_buzzer;
    logic              m_warn_relay;
    logic              m_fault_raise;
    logic              psel               = 1'b0;
    logic              penable            = 1'b0;
    logic              pwrite             = 1'b0;
    logic [ADDR_W-1:0] paddr              = '0;
    logic [31:0]       pwdata             = '0;
    logic [31:0]       prdata;
    logic              pready;

    int n_mismatch;
    int alarms_due;

    // Stimulus state
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          n_sent = 0;
    int          n_settings = 1;
    logic [31:0] now_ms = 32'd1000;
    int          target_mv = 24000;
    int          jitter_mv = 300;
    int          step_max = 40;
    vwm_cfg_t    cur;

    voltage_warning_monitor_unit u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_time_ms          (s_time_ms),
        .s_voltage_mv       (s_voltage_mv),
        .s_sensor_update_ms (s_sensor_update_ms),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_alarm_level      (m_alarm_level),
        .m_buzzer           (m_buzzer),
        .m_warn_relay       (m_warn_relay),
        .m_fault_raise      (m_fault_raise),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    vwm_alarm_check u_check (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_time_ms          (s_time_ms),
        .s_voltage_mv       (s_voltage_mv),
        .s_sensor_update_ms (s_sensor_update_ms),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_alarm_level      (m_alarm_level),
        .m_buzzer           (m_buzzer),
        .m_warn_relay       (m_warn_relay),
        .m_fault_raise      (m_fault_raise),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .n_mismatch         (n_mismatch),
        .alarms_due         (alarms_due)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Stall the result channel at the current rate
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one input request, with an optional idle gap first
    task automatic send_req(input logic [31:0] t, input logic [15:0] mv,
                            input logic [31:0] upd);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid            <= 1'b1;
        s_time_ms          <= t;
        s_voltage_mv       <= mv;
        s_sensor_update_ms <= upd;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
    endtask

    // Advance time and send a fresh sample
    task automatic drive_at(input int dt, input logic [15:0] mv);
        now_ms += 32'(dt);
        send_req(now_ms, mv, now_ms);
    endtask

    // Drop valid and hold until every predicted result has come back
    task automatic hold_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (alarms_due != 0);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] idx,
                              input logic [31:0] data);
        psel   <= 1'b1;
        pwrite <= wr;
        paddr  <= ADDR_W'({idx, 2'b00});
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        penable <= 1'b0;
    endtask

    // Write all registers while idle, then read them back
    task automatic program_regs(input vwm_cfg_t c);
        logic [2:0] idx;
        hold_for_results();
        repeat (3) @(posedge aclk);
        apb_access(1'b1, REG_WARN_LOW,      {16'($urandom), c.warn_low_mv});
        apb_access(1'b1, REG_WARN_CRITICAL, {16'($urandom), c.warn_critical_mv});
        apb_access(1'b1, REG_HYSTERESIS,    {16'($urandom), c.hysteresis_mv});
        apb_access(1'b1, REG_SENSOR_TMO,    c.sensor_timeout_ms);
        apb_access(1'b1, REG_WARN_BLINK,    {16'($urandom), c.warn_blink_ms});
        apb_access(1'b1, REG_CRIT_BLINK,    {16'($urandom), c.crit_blink_ms});
        apb_access(1'b1, REG_DEBOUNCE,      {16'($urandom), c.debounce_ms});
        for (int i = 0; i < 7; i++) begin
            idx = 3'(i);
            apb_access(1'b0, idx, 32'($urandom));
        end
        psel <= 1'b0;
        cur = c;
        n_settings++;
    endtask

    function automatic vwm_cfg_t phase_cfg(input int p);
        vwm_cfg_t c;
        c.warn_low_mv       = 16'(15000 + $urandom_range(15000));
        c.warn_critical_mv  = c.warn_low_mv - 16'($urandom_range(3000));
        c.hysteresis_mv     = 16'($urandom_range(1500));
        c.sensor_timeout_ms = 32'(50 + $urandom_range(2000));
        c.warn_blink_ms     = 16'($urandom_range(400));
        c.crit_blink_ms     = 16'($urandom_range(200));
        c.debounce_ms       = 16'($urandom_range(150));
        case (p)
            0: begin
                c.warn_low_mv       = RST_WARN_LOW;
                c.warn_critical_mv  = RST_WARN_CRITICAL;
                c.hysteresis_mv     = RST_HYSTERESIS;
                c.sensor_timeout_ms = RST_SENSOR_TMO;
                c.warn_blink_ms     = RST_WARN_BLINK;
                c.crit_blink_ms     = RST_CRIT_BLINK;
                c.debounce_ms       = RST_DEBOUNCE;
            end
            2: c = '0;
            3: c = '1;
            5: begin
                // Tight setting: no margin, no debounce, blink periods of 0 and 1 ms
                c.warn_low_mv       = 16'd22000;
                c.warn_critical_mv  = 16'd21000;
                c.hysteresis_mv     = 16'd0;
                c.sensor_timeout_ms = 32'd500;
                c.warn_blink_ms     = 16'd0;
                c.crit_blink_ms     = 16'd1;
                c.debounce_ms       = 16'd0;
            end
            7: c = {$urandom, $urandom, $urandom, $urandom};
            default: ;
        endcase
        return c;
    endfunction

    // Aim the voltage walk at a threshold of the current setting
    task automatic pick_target();
        case ($urandom_range(5))
            0: target_mv = int'(cur.warn_low_mv);
            1: target_mv = int'(cur.warn_critical_mv);
            2: target_mv = int'(cur.warn_low_mv) + int'(cur.hysteresis_mv);
            3: target_mv = int'(cur.warn_critical_mv) + int'(cur.hysteresis_mv);
            4: target_mv = 24000;
            default: target_mv = ($urandom_range(1)) ? int'(MV_VALID_MIN) : int'(MV_VALID_MAX);
        endcase
        jitter_mv = $urandom_range(1000);
    endtask

    // Mostly a coherent sample stream, with some stale and noise requests
    task automatic send_random();
        int          pick;
        int          v;
        int          age_max;
        logic [31:0] upd;
        pick = $urandom_range(99);
        if (pick < 5) begin
            send_req($urandom, 16'($urandom), $urandom);
            return;
        end
        if ($urandom_range(19) == 0) pick_target();
        if ($urandom_range(15) == 0) now_ms += 32'($urandom_range(70000));
        else now_ms += 32'($urandom_range(step_max));
        v = target_mv + int'($urandom_range(2 * jitter_mv)) - jitter_mv;
        if (v < 0) v = 0;
        else if (v > 65535) v = 65535;
        age_max = (cur.sensor_timeout_ms > 32'd2000) ? 2000 : int'(cur.sensor_timeout_ms);
        if (pick < 10) upd = now_ms - cur.sensor_timeout_ms - 32'd1 - 32'($urandom_range(50));
        else upd = now_ms - 32'($urandom_range(age_max));
        send_req(now_ms, 16'(v), upd);
    endtask

    task automatic set_mode(input int m);
        case (m)
            1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
            3: begin send_idle_pct = 16; recv_stall_pct = 16; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
        endcase
    endtask

    initial begin
        cur = phase_cfg(0);
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, median window edges, fail-safe entry
        drive_at(0, 16'd24000);
        drive_at(10, 16'd0);
        drive_at(10, 16'd65535);
        drive_at(10, 16'd0);
        drive_at(10, 16'd0);
        drive_at(10, 16'd65535);
        drive_at(10, 16'd65535);
        drive_at(10, 16'd9999);
        drive_at(10, 16'd9999);
        drive_at(10, 16'd10000);
        drive_at(10, 16'd10000);
        drive_at(10, 16'd35001);
        drive_at(10, 16'd35001);
        // Step down from critical to normal through debounce
        drive_at(10, 16'd35000);
        drive_at(10, 16'd35000);
        drive_at(101, 16'd35000);
        drive_at(10, 16'd35000);
        drive_at(101, 16'd35000);
        // Rise to warning: debounce not yet exceeded, then exceeded, then blink
        drive_at(10, 16'd21500);
        drive_at(10, 16'd21500);
        drive_at(50, 16'd21500);
        drive_at(51, 16'd21500);
        drive_at(500, 16'd21500);
        // Stale sensor at the timeout and one past it, across time wrap
        send_req(now_ms + 32'd1, 16'd21500, now_ms - 32'd999);
        send_req(now_ms + 32'd2, 16'd21500, now_ms - 32'd999);
        now_ms = 32'hFFFF_FFF0;
        drive_at(32, 16'd24000);
        send_req(32'h0000_0010, 16'd24000, 32'hFFFF_FC00);

        // Random phases over several register settings and idle patterns
        for (int p = 0; p < 8; p++) begin
            program_regs(phase_cfg(p));
            set_mode(p % 4);
            step_max = (int'(cur.debounce_ms) / 2 + 20 > 5000) ? 5000
                                                               : int'(cur.debounce_ms) / 2 + 20;
            pick_target();
            for (int i = 0; i < 120; i++) begin
                if (p == 1 && i == 60) hold_for_results();
                send_random();
            end
        end

        hold_for_results();
        repeat (4) @(posedge aclk);
        $display("Covered %0d input requests under %0d register settings,", n_sent, n_settings);
        $display("with free flow, sender gaps, receiver stalls and both mixed.");
        if (n_mismatch == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Bound the run
    initial begin
        #(2_000_000);
        $display("timeout with %0d results outstanding", alarms_due);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
